/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/sru_pkg.sv */
`timescale 1ns / 1ps

package sru_pkg;

  localparam int DEPTH      = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int BYTE_W     = 8;
  localparam int NAME_BYTES = 9;
  localparam int KEY_W      = NAME_BYTES * BYTE_W;
  localparam int AGE_W      = 8;
  localparam int PHONE_W    = 31;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_RECORD    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [AGE_W-1:0]   age;
    logic [PHONE_W-1:0] phone;
  } record_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    record_t  rec;
  } cell_ctrl_t;

  // A name ends at its first zero byte; every byte after it reads as zero.
  function automatic logic [KEY_W-1:0] clean_name(input logic [63:0] head,
                                                  input logic [BYTE_W-1:0] tail);
    logic [KEY_W-1:0] key;
    logic             seen;
    key  = {head, tail};
    seen = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (key[KEY_W-1-BYTE_W*i -: BYTE_W] == '0) begin
        seen = 1'b1;
      end
      if (seen) begin
        key[KEY_W-1-BYTE_W*i -: BYTE_W] = '0;
      end
    end
    return key;
  endfunction

endpackage

/* rtl/sru_cmd_if.sv */
`timescale 1ns / 1ps

interface sru_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] name_head;
  logic [7:0]  name_tail;
  logic [7:0]  age;
  logic [30:0] phone;

  modport source (output valid, command, name_head, name_tail, age, phone, input ready);
  modport sink (input valid, command, name_head, name_tail, age, phone, output ready);
endinterface

/* rtl/sru_rsp_if.sv */
`timescale 1ns / 1ps

interface sru_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_name_head;
  logic [7:0]  out_name_tail;
  logic [7:0]  out_age;
  logic [30:0] out_phone;
  logic        last;

  modport source (output valid, status, out_name_head, out_name_tail, out_age, out_phone,
                  last, input ready);
  modport sink (input valid, status, out_name_head, out_name_tail, out_age, out_phone,
                last, output ready);
endinterface

/* rtl/sru_cell.sv */
`timescale 1ns / 1ps

// One slot of the sorted chain. It holds a record and either keeps it, takes
// the new record, takes its left neighbor (insert shifts right), or takes its
// right neighbor (rotate toward the head).
module sru_cell (
  input  logic                clk,
  input  sru_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  sru_pkg::record_t    left_rec,
  input  logic                left_gt,
  input  sru_pkg::record_t    right_rec,
  output sru_pkg::record_t    rec,
  output logic                gt
);

  sru_pkg::record_t rec_next;

  // An empty slot counts as greater, so a new record lands in the first one.
  assign gt = !valid || (ctrl.rec.key < rec.key);

  always_comb begin
    case (ctrl.op)
      sru_pkg::OP_INSERT: begin
        if (left_gt) begin
          rec_next = left_rec;
        end else if (gt) begin
          rec_next = ctrl.rec;
        end else begin
          rec_next = rec;
        end
      end
      sru_pkg::OP_ROTATE: rec_next = right_rec;
      default:            rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

/* rtl/sorted_record_list_unit.sv */
// Sorted record list: keeps up to 32 records (9-byte name, age, phone) in
// ascending byte-wise name order in a chain of cells that compare against a
// broadcast record and shift in parallel. One command transaction is taken
// at a time; the input is ready only while the controller is idle. Insert and
// remove register the command, then shift the whole chain at once when the
// output register is free, and give one result. Search rotates the chain
// once per cycle past the head cell, a full turn of the N stored entries so
// that the order is restored, and then reports. List emits the head cell and
// rotates once per result, holding while the output is not taken. The output
// register lets the next command be accepted while the last result still
// waits to be taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_record_list_unit (
  input logic       clk,
  input logic       rst,
  sru_cmd_if.sink   cmd,
  sru_rsp_if.source rsp
);

  localparam int DEPTH = sru_pkg::DEPTH;
  localparam int CNT_W = sru_pkg::CNT_W;
  localparam int IDX_W = sru_pkg::IDX_W;

  // Controller state and command registers.
  sru_pkg::state_t  state, state_next;
  sru_pkg::cmd_t    cmd_q;
  sru_pkg::record_t rec_q;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] step;
  logic             found;
  sru_pkg::record_t hit_rec;

  // Output register.
  logic             out_valid;
  sru_pkg::status_t out_status;
  sru_pkg::record_t out_rec;
  logic             out_last;

  // The chain.
  sru_pkg::cell_ctrl_t ctrl;
  sru_pkg::record_t    cell_rec [DEPTH];
  sru_pkg::record_t    right_rec [DEPTH];
  logic [DEPTH-1:0]    cell_gt;
  logic [DEPTH-1:0]    cell_valid;

  // Decoded controls.
  logic             out_load;
  logic             emit;
  sru_pkg::status_t emit_status;
  sru_pkg::record_t emit_rec;
  logic             emit_last;
  logic             count_inc;
  logic             count_dec;
  logic             scan_start;
  logic             scan_adv;
  logic             capture;
  logic             last_step;
  logic             head_match;

  assign cmd.ready  = (state == sru_pkg::S_IDLE);
  assign out_load   = !out_valid || rsp.ready;
  assign last_step  = ({1'b0, step} + CNT_W'(1)) == count;
  assign head_match = (cell_rec[0].key == rec_q.key);

  // Each cell sees its left neighbor for insert and its right neighbor for
  // rotate. The head wraps to the last stored entry so a full turn of the
  // valid entries brings them back in order; on remove the wrapped copy falls
  // outside the shortened list.
  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    assign cell_valid[i] = CNT_W'(i) < count;

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec[i] = cell_rec[0];
    end else begin : g_mid
      assign right_rec[i] = (CNT_W'(i + 1) == count) ? cell_rec[0] : cell_rec[i+1];
    end

    if (i == 0) begin : g_head
      sru_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (cell_valid[i]),
        .left_rec  (ctrl.rec),
        .left_gt   (1'b0),
        .right_rec (right_rec[i]),
        .rec       (cell_rec[i]),
        .gt        (cell_gt[i])
      );
    end else begin : g_body
      sru_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (cell_valid[i]),
        .left_rec  (cell_rec[i-1]),
        .left_gt   (cell_gt[i-1]),
        .right_rec (right_rec[i]),
        .rec       (cell_rec[i]),
        .gt        (cell_gt[i])
      );
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sru_pkg::S_IDLE: begin
        if (cmd.valid) begin
          state_next = sru_pkg::S_EXEC;
        end
      end
      sru_pkg::S_EXEC: begin
        if (scan_start) begin
          state_next = sru_pkg::S_SCAN;
        end else if (out_load) begin
          state_next = sru_pkg::S_IDLE;
        end
      end
      sru_pkg::S_SCAN: begin
        if (scan_adv && last_step) begin
          state_next = (cmd_q == sru_pkg::CMD_SEARCH) ? sru_pkg::S_REPORT : sru_pkg::S_IDLE;
        end
      end
      sru_pkg::S_REPORT: begin
        if (out_load) begin
          state_next = sru_pkg::S_IDLE;
        end
      end
      default: state_next = sru_pkg::S_IDLE;
    endcase
  end

  // Controls for the chain, the counters and the output register.
  always_comb begin
    ctrl.op     = sru_pkg::OP_HOLD;
    ctrl.rec    = rec_q;
    emit        = 1'b0;
    emit_status = sru_pkg::ST_DONE;
    emit_rec    = '0;
    emit_last   = 1'b1;
    count_inc   = 1'b0;
    count_dec   = 1'b0;
    scan_start  = 1'b0;
    scan_adv    = 1'b0;
    capture     = 1'b0;
    case (state)
      sru_pkg::S_EXEC: begin
        case (cmd_q)
          sru_pkg::CMD_INSERT: begin
            if (out_load) begin
              emit = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                emit_status = sru_pkg::ST_FULL;
              end else begin
                ctrl.op   = sru_pkg::OP_INSERT;
                count_inc = 1'b1;
              end
            end
          end
          sru_pkg::CMD_REMOVE: begin
            if (out_load) begin
              emit = 1'b1;
              if (count == '0) begin
                emit_status = sru_pkg::ST_EMPTY;
              end else begin
                ctrl.op   = sru_pkg::OP_ROTATE;
                count_dec = 1'b1;
              end
            end
          end
          sru_pkg::CMD_SEARCH: begin
            if (count != '0) begin
              scan_start = 1'b1;
            end else if (out_load) begin
              emit        = 1'b1;
              emit_status = sru_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            if (count != '0) begin
              scan_start = 1'b1;
            end else if (out_load) begin
              emit        = 1'b1;
              emit_status = sru_pkg::ST_EMPTY;
            end
          end
        endcase
      end
      sru_pkg::S_SCAN: begin
        if (cmd_q == sru_pkg::CMD_LIST) begin
          scan_adv = out_load;
          if (out_load) begin
            ctrl.op     = sru_pkg::OP_ROTATE;
            emit        = 1'b1;
            emit_status = sru_pkg::ST_RECORD;
            emit_rec    = cell_rec[0];
            emit_last   = last_step;
          end
        end else begin
          scan_adv = 1'b1;
          ctrl.op  = sru_pkg::OP_ROTATE;
          capture  = !found && head_match;
        end
      end
      sru_pkg::S_REPORT: begin
        if (out_load) begin
          emit = 1'b1;
          if (found) begin
            emit_status = sru_pkg::ST_RECORD;
            emit_rec    = hit_rec;
          end else begin
            emit_status = sru_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sru_pkg::S_IDLE;
      count     <= '0;
      step      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) begin
        count <= count + CNT_W'(1);
      end else if (count_dec) begin
        count <= count - CNT_W'(1);
      end
      if (scan_start) begin
        step  <= '0;
        found <= 1'b0;
      end else if (scan_adv) begin
        step <= step + IDX_W'(1);
        if (capture) begin
          found <= 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q     <= sru_pkg::cmd_t'(cmd.command);
      rec_q.key <= sru_pkg::clean_name(cmd.name_head, cmd.name_tail);
      rec_q.age <= cmd.age;
      rec_q.phone <= cmd.phone;
    end
    if (capture) begin
      hit_rec <= cell_rec[0];
    end
    if (emit) begin
      out_status <= emit_status;
      out_rec    <= emit_rec;
      out_last   <= emit_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.out_name_head = out_rec.key[sru_pkg::KEY_W-1 -: 64];
  assign rsp.out_name_tail = out_rec.key[sru_pkg::BYTE_W-1:0];
  assign rsp.out_age       = out_rec.age;
  assign rsp.out_phone     = out_rec.phone;
  assign rsp.last          = out_last;

  // The fill count never runs past the number of cells.
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  // The fill count moves only while a command is being carried out.
  `ASSERT_IMPLIES(a_count_in_exec, clk, rst, count != $past(count), $past(state) == sru_pkg::S_EXEC)
  // A scan never walks past the stored entries.
  `ASSERT_IMPLIES(a_scan_range, clk, rst, state == sru_pkg::S_SCAN, ({1'b0, step} < count))
  // A result is only loaded when the output register is free.
  `ASSERT_IMPLIES(a_emit_free, clk, rst, emit, !out_valid || rsp.ready)

endmodule
